[rtl/lsd_pkg.sv]
`timescale 1ns / 1ps
// Package for the LRU stack distance block: widths, reset values and the link type
// that runs along the row of stack cells. It depends on nothing else.
package lsd_pkg;

	localparam int CAPACITY_DEF  = 16;
	localparam int PAGE_BITS_DEF = 32;
	localparam int CAP_REG_W     = 5;
	localparam int DEPTH_W       = 4;

	localparam logic [CAP_REG_W-1:0] CAP_RESET = 5'd16;

	typedef struct packed {
		logic               found;
		logic [DEPTH_W-1:0] depth;
	} lsd_link_t;

endpackage

[rtl/lsd_if.sv]
`timescale 1ns / 1ps
// Channel interfaces of the LRU stack distance block: page requests, results and
// capacity writes. Uses lsd_pkg for the field widths.
interface lsd_page_if #(
	parameter int PAGE_BITS = lsd_pkg::PAGE_BITS_DEF
);
	logic                 valid;
	logic                 ready;
	logic [PAGE_BITS-1:0] page_number;

	modport source (output valid, output page_number, input ready);
	modport sink   (input valid, input page_number, output ready);
endinterface

interface lsd_result_if;
	logic                         valid;
	logic                         ready;
	logic                         hit;
	logic [lsd_pkg::DEPTH_W-1:0]  depth;

	modport source (output valid, output hit, output depth, input ready);
	modport sink   (input valid, input hit, input depth, output ready);
endinterface

interface lsd_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [lsd_pkg::CAP_REG_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[rtl/lsd_cell.sv]
`timescale 1ns / 1ps
// One stack position: holds a page, compares it with the requested page and takes
// its neighbor's page when the entries in front of it move down. Uses lsd_pkg.
module lsd_cell #(
	parameter int INDEX     = 0,
	parameter int CNT_W     = 5,
	parameter int PAGE_BITS = 32
) (
	input  logic                   clk,
	input  logic                   shift_en,
	input  logic [PAGE_BITS-1:0]   key,
	input  logic [PAGE_BITS-1:0]   prev_page,
	input  logic [CNT_W-1:0]       occ,
	input  lsd_pkg::lsd_link_t     link_in,
	output lsd_pkg::lsd_link_t     link_out,
	output logic [PAGE_BITS-1:0]   page_out
);
	import lsd_pkg::*;

	logic [PAGE_BITS-1:0] page_q;
	logic                 match;
	logic                 first;

	assign match = (page_q == key) && (CNT_W'(INDEX) < occ);
	assign first = match && !link_in.found;

	assign link_out.found = link_in.found | match;
	assign link_out.depth = link_in.depth | (first ? DEPTH_W'(INDEX) : '0);
	assign page_out       = page_q;

	always_ff @(posedge clk) begin
		if (shift_en && !link_in.found) begin
			page_q <= prev_page;
		end
	end

endmodule

[rtl/lru_stack_distance.sv]
`timescale 1ns / 1ps
// LRU stack distance block: a row of CAPACITY compare-and-shift cells, most recent first.
// An accepted request's result is registered and shown in the next cycle. One request
// per cycle is taken, limited only by the single output register when results stall.
// The search, reorder and count update all happen in the accept cycle along the cell row.
// Reset empties the stack and sets the capacity to 16; stored pages are not cleared.
// Depends on lsd_pkg, lsd_if and lsd_cell.
module lru_stack_distance #(
	parameter int CAPACITY  = lsd_pkg::CAPACITY_DEF,
	parameter int PAGE_BITS = lsd_pkg::PAGE_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	lsd_page_if.sink     page,
	lsd_result_if.source result,
	lsd_cfg_if.sink      cfg
);
	import lsd_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > CAP_REG_W) ? CNT_W : CAP_REG_W;

	logic [CAP_REG_W-1:0] cap_q;
	logic [CNT_W-1:0]     occ_q;
	logic                 res_valid_q;
	logic                 hit_q;
	logic [DEPTH_W-1:0]   depth_q;

	logic [CMP_W-1:0]     cap_cmp;
	logic [CNT_W-1:0]     eff_cap;
	logic                 in_fire;
	logic                 cfg_fire;

	lsd_link_t            links [0:CAPACITY];
	logic [PAGE_BITS-1:0] pages [0:CAPACITY-1];

	assign cap_cmp  = (CMP_W'(cap_q) > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY) : CMP_W'(cap_q);
	assign eff_cap  = cap_cmp[CNT_W-1:0];
	assign page.ready = !res_valid_q || result.ready;
	assign in_fire  = page.valid && page.ready;
	assign cfg.ready = 1'b1;
	assign cfg_fire = cfg.valid;

	assign links[0] = '0;

	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic [PAGE_BITS-1:0] prev;
		if (k == 0) begin : g_head
			assign prev = page.page_number;
		end else begin : g_body
			assign prev = pages[k-1];
		end
		lsd_cell #(
			.INDEX     (k),
			.CNT_W     (CNT_W),
			.PAGE_BITS (PAGE_BITS)
		) u_cell (
			.clk       (clk),
			.shift_en  (in_fire),
			.key       (page.page_number),
			.prev_page (prev),
			.occ       (occ_q),
			.link_in   (links[k]),
			.link_out  (links[k+1]),
			.page_out  (pages[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			occ_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_fire) begin
				cap_q <= cfg.data;
				occ_q <= '0;
			end else if (in_fire && !links[CAPACITY].found) begin
				occ_q <= (occ_q < eff_cap) ? occ_q + CNT_W'(1) : eff_cap;
			end
			if (in_fire) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			hit_q   <= links[CAPACITY].found;
			depth_q <= links[CAPACITY].depth;
		end
	end

	assign result.valid = res_valid_q;
	assign result.hit   = hit_q;
	assign result.depth = depth_q;

endmodule

[rtl/lsd_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the LRU stack distance block, bound to its top level.
// Uses lsd_pkg for the depth width.
module lsd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        page_valid,
	input logic                        page_ready,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic                        res_hit,
	input logic [lsd_pkg::DEPTH_W-1:0] res_depth
);
	import lsd_pkg::*;

	// A miss always reports a depth of zero.
	a_miss_depth: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_hit |-> res_depth == '0)
		else $error("miss reported with nonzero depth");

	// An accepted request shows its result in the next cycle.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		page_valid && page_ready |=> res_valid)
		else $error("result missing one cycle after accepted request");

	// No request is taken while a result waits and cannot leave.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |-> !page_ready)
		else $error("request accepted while output is stalled");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_hit) && $stable(res_depth))
		else $error("stalled result changed");

endmodule

bind lru_stack_distance lsd_checker u_lsd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.page_valid (page.valid),
	.page_ready (page.ready),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_hit    (result.hit),
	.res_depth  (result.depth)
);
